FILE: design/akd_pkg.sv
`default_nettype none

package akd_pkg;

    // Width of the lone-ESC tick counter.
    localparam int TIMEOUT_WIDTH = 16;
    // Width used when the counter is compared with the programmed timeout.
    localparam int CNT_CMP_W = (TIMEOUT_WIDTH > 16) ? TIMEOUT_WIDTH : 16;

    // Field widths of the channels.
    localparam int KEY_W     = 6;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int TICKS_W   = 16;

    typedef logic [KEY_W-1:0]     t_key;
    typedef logic [CHAR_W-1:0]    t_char;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_BRACKET,
        PH_DIGIT,
        PH_MOD,
        PH_DIR
    } t_phase;

    // Input word operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_BACKSPACE = 3'd0;
    localparam t_cfg_idx CFG_DELETE    = 3'd1;
    localparam t_cfg_idx CFG_INTERRUPT = 3'd2;
    localparam t_cfg_idx CFG_END_INPUT = 3'd3;
    localparam t_cfg_idx CFG_END_LINE  = 3'd4;
    localparam t_cfg_idx CFG_TIMEOUT   = 3'd5;

    // Key codes.
    localparam t_key K_PLAIN      = 6'd0;
    localparam t_key K_ESC        = 6'd1;
    localparam t_key K_END        = 6'd2;
    localparam t_key K_HOME       = 6'd3;
    localparam t_key K_INS        = 6'd4;
    localparam t_key K_DEL        = 6'd5;
    localparam t_key K_PGUP       = 6'd6;
    localparam t_key K_PGDN       = 6'd7;
    localparam t_key K_UP         = 6'd8;
    localparam t_key K_SHIFTTAB   = 6'd12;
    localparam t_key K_CTRL_BASE  = 6'd13;
    localparam t_key K_SHIFT_BASE = 6'd19;
    localparam t_key K_CS_BASE    = 6'd25;
    localparam t_key K_BACK       = 6'd31;
    localparam t_key K_INTR       = 6'd32;
    localparam t_key K_EOI        = 6'd33;
    localparam t_key K_ENTER      = 6'd34;
    localparam t_key K_LAST       = K_ENTER;

    // Characters of the escape sequences.
    localparam t_char CH_ESC     = 8'h1B;
    localparam t_char CH_BRACKET = 8'h5B;
    localparam t_char CH_TILDE   = 8'h7E;
    localparam t_char CH_SEMI    = 8'h3B;
    localparam t_char CH_ZERO    = 8'h30;
    localparam t_char CH_ONE     = 8'h31;
    localparam t_char CH_TWO     = 8'h32;
    localparam t_char CH_THREE   = 8'h33;
    localparam t_char CH_FIVE    = 8'h35;
    localparam t_char CH_SIX     = 8'h36;
    localparam t_char CH_NINE    = 8'h39;
    localparam t_char CH_Z       = 8'h5A;

    // Reset values of the configuration registers.
    localparam t_char               RST_BACKSPACE = 8'd8;
    localparam t_char               RST_DELETE    = 8'd127;
    localparam t_char               RST_INTERRUPT = 8'd3;
    localparam t_char               RST_END_INPUT = 8'd4;
    localparam t_char               RST_END_LINE  = 8'd13;
    localparam logic [TICKS_W-1:0]  RST_TIMEOUT   = 16'd100;

    // Direction letter decode: up, down, right, left, home, end.
    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_dir;

    function automatic t_dir dir_decode(input t_char b);
        t_dir d;
        d.hit = 1'b1;
        d.idx = 3'd0;
        case (b)
            8'h41: d.idx = 3'd0;
            8'h42: d.idx = 3'd1;
            8'h43: d.idx = 3'd2;
            8'h44: d.idx = 3'd3;
            8'h48: d.idx = 3'd4;
            8'h46: d.idx = 3'd5;
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

    // Unmodified key for a direction index.
    function automatic t_key plain_dir(input logic [2:0] idx);
        t_key k;
        case (idx)
            3'd4:    k = K_HOME;
            3'd5:    k = K_END;
            default: k = K_UP + t_key'(idx);
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

FILE: design/akd_if.sv
`default_nettype none

// Input channel: one byte or one tick per word.
interface akd_in_if
    import akd_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        operation;
    t_char       data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// Result channel: one decoded key per word.
interface akd_out_if
    import akd_pkg::*;
();
    logic        valid;
    logic        ready;
    t_key        key_code;
    t_char       char_value;

    modport source (output valid, output key_code, output char_value, input ready);
    modport sink   (input valid, input key_code, input char_value, output ready);
endinterface

// Configuration write channel.
interface akd_cfg_if
    import akd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_cfg_idx             index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/ansi_escape_key_decoder_core.sv
// ANSI / VT100 terminal key decoder.
// i_in carries one word per terminal event: operation 0 is a received byte in
// data_byte, operation 1 is one time tick. o_out carries decoded keys as
// key_code and char_value (the character itself for plain keys, else zero).
// i_cfg writes the five control codes and the lone-ESC timeout by index; it
// is always ready and is meant to be written only while the decoder is idle.
// Each input word is decoded in the cycle it is accepted: the parser state
// and the result register update at that edge, so a key appears on o_out in the
// cycle after the word that completes it. Words that only advance a sequence
// produce no key. One word per cycle is taken as long as the result register
// is empty or is being drained in the same cycle; the single result register
// sets that figure. When the receiver stalls with a key pending, i_in.ready
// drops until the key is taken.
// Reset (synchronous, active low) returns the parser to idle, clears the
// tick counter and the held digit and modifier, empties the result register
// and restores the configuration defaults.
`default_nettype none

module ansi_escape_key_decoder_core
    import akd_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    akd_in_if.sink       i_in,
    akd_out_if.source    o_out,
    akd_cfg_if.sink      i_cfg
);

    // Configuration registers.
    t_char               r_back_code;
    t_char               r_del_code;
    t_char               r_intr_code;
    t_char               r_eoi_code;
    t_char               r_enter_code;
    logic [TICKS_W-1:0]  r_timeout;

    // Parser state.
    t_phase                   r_phase,  n_phase;
    t_char                    r_digit,  n_digit;
    t_char                    r_mod,    n_mod;
    logic [TIMEOUT_WIDTH-1:0] r_count,  n_count;

    // Result register.
    logic  r_out_valid;
    t_key  r_key;
    t_char r_char;

    // Decoder outputs for the current word.
    logic  res_valid;
    t_key  res_key;
    t_char res_char;

    logic                     in_ready;
    logic                     in_accept;
    logic [TIMEOUT_WIDTH-1:0] count_inc;
    t_dir                     dir;

    assign in_ready    = !r_out_valid || o_out.ready;
    assign in_accept   = i_in.valid && in_ready;
    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.key_code   = r_key;
    assign o_out.char_value = r_char;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_back_code  <= RST_BACKSPACE;
            r_del_code   <= RST_DELETE;
            r_intr_code  <= RST_INTERRUPT;
            r_eoi_code   <= RST_END_INPUT;
            r_enter_code <= RST_END_LINE;
            r_timeout    <= RST_TIMEOUT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BACKSPACE: r_back_code  <= i_cfg.data[CHAR_W-1:0];
                CFG_DELETE:    r_del_code   <= i_cfg.data[CHAR_W-1:0];
                CFG_INTERRUPT: r_intr_code  <= i_cfg.data[CHAR_W-1:0];
                CFG_END_INPUT: r_eoi_code   <= i_cfg.data[CHAR_W-1:0];
                CFG_END_LINE:  r_enter_code <= i_cfg.data[CHAR_W-1:0];
                CFG_TIMEOUT:   r_timeout    <= i_cfg.data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturating tick count and direction letter decode.
    assign count_inc = (r_count == '1) ? r_count : r_count + TIMEOUT_WIDTH'(1);
    assign dir       = dir_decode(i_in.data_byte);

    // Next parser state and the key produced by the accepted word.
    always_comb begin
        n_phase   = r_phase;
        n_digit   = r_digit;
        n_mod     = r_mod;
        n_count   = r_count;
        res_valid = 1'b0;
        res_key   = K_PLAIN;
        res_char  = '0;

        if (in_accept) begin
            if (i_in.operation == OP_TICK) begin
                if (r_phase == PH_ESC) begin
                    n_count = count_inc;
                    if (CNT_CMP_W'(count_inc) >= CNT_CMP_W'(r_timeout)) begin
                        res_valid = 1'b1;
                        res_key   = K_ESC;
                    end
                end
            end else begin
                // Any key ends the sequence; the cases below override this.
                res_valid = 1'b1;
                res_key   = K_PLAIN;
                res_char  = CH_ESC;
                case (r_phase)
                    PH_ESC: begin
                        if (i_in.data_byte == CH_BRACKET) begin
                            res_valid = 1'b0;
                            n_phase   = PH_BRACKET;
                        end
                    end
                    PH_BRACKET: begin
                        if (i_in.data_byte >= CH_ZERO && i_in.data_byte <= CH_NINE) begin
                            res_valid = 1'b0;
                            n_digit   = i_in.data_byte;
                            n_phase   = PH_DIGIT;
                        end else if (i_in.data_byte == CH_Z) begin
                            res_key  = K_SHIFTTAB;
                            res_char = '0;
                        end else if (dir.hit) begin
                            res_key  = plain_dir(dir.idx);
                            res_char = '0;
                        end
                    end
                    PH_DIGIT: begin
                        if (i_in.data_byte == CH_TILDE) begin
                            res_char = '0;
                            case (r_digit)
                                CH_ZERO:  res_key = K_END;
                                CH_ONE:   res_key = K_HOME;
                                CH_TWO:   res_key = K_INS;
                                CH_THREE: res_key = K_DEL;
                                CH_FIVE:  res_key = K_PGUP;
                                CH_SIX:   res_key = K_PGDN;
                                default: begin
                                    res_key  = K_PLAIN;
                                    res_char = CH_ESC;
                                end
                            endcase
                        end else if (i_in.data_byte == CH_SEMI) begin
                            if (r_digit == CH_ONE) begin
                                res_valid = 1'b0;
                                n_phase   = PH_MOD;
                            end else begin
                                res_key  = K_ESC;
                                res_char = '0;
                            end
                        end
                    end
                    PH_MOD: begin
                        res_valid = 1'b0;
                        n_mod     = i_in.data_byte;
                        n_phase   = PH_DIR;
                    end
                    PH_DIR: begin
                        if (dir.hit) begin
                            res_char = '0;
                            if (r_mod == CH_FIVE) begin
                                res_key = K_CTRL_BASE + t_key'(dir.idx);
                            end else if (r_mod == CH_TWO) begin
                                res_key = K_SHIFT_BASE + t_key'(dir.idx);
                            end else if (r_mod == CH_SIX) begin
                                res_key = K_CS_BASE + t_key'(dir.idx);
                            end else begin
                                res_key = plain_dir(dir.idx);
                            end
                        end
                    end
                    default: begin
                        // Idle: ESC opens a sequence, else control codes in priority order.
                        res_char = '0;
                        if (i_in.data_byte == CH_ESC) begin
                            res_valid = 1'b0;
                            n_phase   = PH_ESC;
                            n_count   = '0;
                        end else if (i_in.data_byte == r_back_code) begin
                            res_key = K_BACK;
                        end else if (i_in.data_byte == r_del_code) begin
                            res_key = K_DEL;
                        end else if (i_in.data_byte == r_intr_code) begin
                            res_key = K_INTR;
                        end else if (i_in.data_byte == r_eoi_code) begin
                            res_key = K_EOI;
                        end else if (i_in.data_byte == r_enter_code) begin
                            res_key = K_ENTER;
                        end else begin
                            res_key  = K_PLAIN;
                            res_char = i_in.data_byte;
                        end
                    end
                endcase
            end
            if (res_valid) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_digit <= '0;
            r_mod   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_digit <= n_digit;
            r_mod   <= n_mod;
            r_count <= n_count;
        end
    end

    // Result register: loads a new key, or empties when the key is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_key  <= res_key;
            r_char <= res_char;
        end
    end

endmodule

`default_nettype wire

FILE: design/akd_checker.sv
`default_nettype none

module akd_checker
    import akd_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_in_operation,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [5:0]  i_out_key_code,
    input wire [7:0]  i_out_char_value
);

    // A pending key is held until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A stalled key blocks further input words.
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input accepted while a key is stalled");

    // Only plain keys carry a character, and codes stay in range.
    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_key_code <= K_LAST) &&
                        (i_out_key_code == K_PLAIN || i_out_char_value == '0))
        else $error("malformed key word");

    // A tick can only ever produce the escape key.
    a_tick_esc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_operation == OP_TICK |=>
            !i_out_valid || i_out_key_code == K_ESC)
        else $error("tick produced a key other than escape");

endmodule

bind ansi_escape_key_decoder_core akd_checker u_akd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_operation   (i_in.operation),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_key_code   (o_out.key_code),
    .i_out_char_value (o_out.char_value)
);

`default_nettype wire

FILE: tb/sv/ansi_escape_key_decoder_core_tb.sv
`timescale 1ns / 1ps

module ansi_escape_key_decoder_core_tb
    import akd_pkg::*;
;

    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 1000;

    // Letters of the cursor sequences not named in the package.
    localparam t_char CH_A    = 8'h41;
    localparam t_char CH_B    = 8'h42;
    localparam t_char CH_C    = 8'h43;
    localparam t_char CH_D    = 8'h44;
    localparam t_char CH_F    = 8'h46;
    localparam t_char CH_H    = 8'h48;
    localparam t_char CH_FOUR = 8'h34;
    localparam t_char NO_CHAR = 8'h00;

    // Direction slots: up, down, right, left, home, end.
    localparam logic [2:0] SLOT_UP    = 3'd0;
    localparam logic [2:0] SLOT_DOWN  = 3'd1;
    localparam logic [2:0] SLOT_RIGHT = 3'd2;
    localparam logic [2:0] SLOT_LEFT  = 3'd3;
    localparam logic [2:0] SLOT_HOME  = 3'd4;
    localparam logic [2:0] SLOT_END   = 3'd5;

    typedef struct packed {
        t_key  key;
        t_char ch;
    } t_keyword;

    // One stimulus word, with an optional typed-in expectation.
    typedef struct packed {
        logic  op;
        t_char b;
        logic  pinned;
        logic  has;
        t_key  k;
        t_char c;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    akd_in_if  in_if ();
    akd_out_if out_if ();
    akd_cfg_if cfg_if ();

    ansi_escape_key_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state and its copy of the registers.
    t_phase                   ph;
    t_char                    held_dig;
    t_char                    held_mod;
    logic [TIMEOUT_WIDTH-1:0] esc_ticks;
    t_char                    bs_code;
    t_char                    del_code;
    t_char                    intr_code;
    t_char                    eoi_code;
    t_char                    enter_code;
    logic [TICKS_W-1:0]       esc_limit;

    t_keyword keys_due[$];

    // Typed-in expectation travelling with the word on the input channel.
    logic     pin_on;
    logic     pin_has;
    t_keyword pin_word;

    bit calm;
    int errors;
    int words_in;
    int bytes_sent;
    int keys_out;
    int esc_keys;
    int settings;

    task automatic note_mismatch(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Advances the predictor by one word; returns 1 when a key comes out.
    function automatic bit decode_word(input logic op, input t_char b, output t_keyword res);
        logic       hit;
        logic       dir_ok;
        logic [2:0] slot;
        t_key       dir_plain;
        hit    = 1'b0;
        res    = {K_PLAIN, NO_CHAR};
        dir_ok = 1'b1;
        slot   = SLOT_UP;
        case (b)
            CH_A:    slot = SLOT_UP;
            CH_B:    slot = SLOT_DOWN;
            CH_C:    slot = SLOT_RIGHT;
            CH_D:    slot = SLOT_LEFT;
            CH_H:    slot = SLOT_HOME;
            CH_F:    slot = SLOT_END;
            default: dir_ok = 1'b0;
        endcase
        if (slot == SLOT_HOME) begin
            dir_plain = K_HOME;
        end else if (slot == SLOT_END) begin
            dir_plain = K_END;
        end else begin
            dir_plain = K_UP + slot;
        end

        if (op == OP_TICK) begin
            // Ticks only matter while a lone ESC waits for its timeout.
            if (ph == PH_ESC) begin
                if (esc_ticks != '1) begin
                    esc_ticks = esc_ticks + 1'b1;
                end
                if (esc_ticks >= esc_limit) begin
                    hit = 1'b1;
                    res = {K_ESC, NO_CHAR};
                end
            end
        end else begin
            case (ph)
                PH_ESC: begin
                    if (b == CH_BRACKET) begin
                        ph = PH_BRACKET;
                    end else begin
                        hit = 1'b1;
                        res = {K_PLAIN, CH_ESC};
                    end
                end
                PH_BRACKET: begin
                    hit = 1'b1;
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        hit      = 1'b0;
                        held_dig = b;
                        ph       = PH_DIGIT;
                    end else if (b == CH_Z) begin
                        res = {K_SHIFTTAB, NO_CHAR};
                    end else if (dir_ok) begin
                        res = {dir_plain, NO_CHAR};
                    end else begin
                        res = {K_PLAIN, CH_ESC};
                    end
                end
                PH_DIGIT: begin
                    hit = 1'b1;
                    res = {K_PLAIN, CH_ESC};
                    if (b == CH_TILDE) begin
                        case (held_dig)
                            CH_ZERO:  res = {K_END, NO_CHAR};
                            CH_ONE:   res = {K_HOME, NO_CHAR};
                            CH_TWO:   res = {K_INS, NO_CHAR};
                            CH_THREE: res = {K_DEL, NO_CHAR};
                            CH_FIVE:  res = {K_PGUP, NO_CHAR};
                            CH_SIX:   res = {K_PGDN, NO_CHAR};
                            default:  res = {K_PLAIN, CH_ESC};
                        endcase
                    end else if (b == CH_SEMI) begin
                        if (held_dig == CH_ONE) begin
                            hit = 1'b0;
                            ph  = PH_MOD;
                        end else begin
                            res = {K_ESC, NO_CHAR};
                        end
                    end
                end
                PH_MOD: begin
                    held_mod = b;
                    ph       = PH_DIR;
                end
                PH_DIR: begin
                    hit = 1'b1;
                    if (!dir_ok) begin
                        res = {K_PLAIN, CH_ESC};
                    end else if (held_mod == CH_FIVE) begin
                        res = {K_CTRL_BASE + slot, NO_CHAR};
                    end else if (held_mod == CH_TWO) begin
                        res = {K_SHIFT_BASE + slot, NO_CHAR};
                    end else if (held_mod == CH_SIX) begin
                        res = {K_CS_BASE + slot, NO_CHAR};
                    end else begin
                        res = {dir_plain, NO_CHAR};
                    end
                end
                default: begin
                    // Idle: ESC opens a sequence, control codes win in fixed order.
                    if (b == CH_ESC) begin
                        ph        = PH_ESC;
                        esc_ticks = '0;
                    end else begin
                        hit = 1'b1;
                        if (b == bs_code) begin
                            res = {K_BACK, NO_CHAR};
                        end else if (b == del_code) begin
                            res = {K_DEL, NO_CHAR};
                        end else if (b == intr_code) begin
                            res = {K_INTR, NO_CHAR};
                        end else if (b == eoi_code) begin
                            res = {K_EOI, NO_CHAR};
                        end else if (b == enter_code) begin
                            res = {K_ENTER, NO_CHAR};
                        end else begin
                            res = {K_PLAIN, b};
                        end
                    end
                end
            endcase
        end
        if (hit) begin
            ph = PH_IDLE;
        end
        return hit;
    endfunction

    // Follows every handshake: register writes, input words and keys.
    always @(posedge i_clk) begin : scoreboard
        t_keyword guess;
        t_keyword got;
        t_keyword want;
        bit       has;
        if (!i_rst_n) begin
            ph         = PH_IDLE;
            held_dig   = '0;
            held_mod   = '0;
            esc_ticks  = '0;
            bs_code    = RST_BACKSPACE;
            del_code   = RST_DELETE;
            intr_code  = RST_INTERRUPT;
            eoi_code   = RST_END_INPUT;
            enter_code = RST_END_LINE;
            esc_limit  = RST_TIMEOUT;
            keys_due.delete();
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_BACKSPACE: bs_code    = cfg_if.data[CHAR_W-1:0];
                    CFG_DELETE:    del_code   = cfg_if.data[CHAR_W-1:0];
                    CFG_INTERRUPT: intr_code  = cfg_if.data[CHAR_W-1:0];
                    CFG_END_INPUT: eoi_code   = cfg_if.data[CHAR_W-1:0];
                    CFG_END_LINE:  enter_code = cfg_if.data[CHAR_W-1:0];
                    CFG_TIMEOUT:   esc_limit  = cfg_if.data[TICKS_W-1:0];
                    default: ;
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                words_in++;
                has = decode_word(in_if.operation, in_if.data_byte, guess);
                if (pin_on) begin
                    has   = pin_has;
                    guess = pin_word;
                end
                if (has) begin
                    keys_due.push_back(guess);
                end
            end
            if (out_if.valid && out_if.ready) begin
                keys_out++;
                got = {out_if.key_code, out_if.char_value};
                if (got.key == K_ESC) begin
                    esc_keys++;
                end
                if (keys_due.size() == 0) begin
                    note_mismatch($sformatf("key %0d char %02h with none expected",
                                            got.key, got.ch));
                end else begin
                    want = keys_due.pop_front();
                    if (got.key !== want.key) begin
                        note_mismatch($sformatf("key_code %0d, expected %0d",
                                                got.key, want.key));
                    end
                    if (got.ch !== want.ch) begin
                        note_mismatch($sformatf("char_value %02h, expected %02h (key %0d)",
                                                got.ch, want.ch, want.key));
                    end
                end
            end
        end
    end

    // Calm stretches run both sides flat out.
    function automatic int pause_len();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic t_char pick_letter();
        case ($urandom_range(0, 6))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_C;
            3:       return CH_D;
            4:       return CH_H;
            5:       return CH_F;
            default: return CH_Z;
        endcase
    endfunction

    // Sends one word; valid stays up if the next word follows without a gap.
    task automatic send_word(input t_row r);
        int gap;
        gap = pause_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= r.op;
        in_if.data_byte <= r.b;
        pin_on          <= r.pinned;
        pin_has         <= r.has;
        pin_word        <= {r.k, r.c};
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        if (r.op == OP_BYTE) begin
            bytes_sent++;
        end
    endtask

    task automatic push_byte(input t_char b);
        t_row r;
        r    = '0;
        r.op = OP_BYTE;
        r.b  = b;
        send_word(r);
    endtask

    task automatic push_tick();
        t_row r;
        r    = '0;
        r.op = OP_TICK;
        r.b  = t_char'($urandom_range(0, 255));
        send_word(r);
    endtask

    // A sequence byte, now and then preceded by a stray tick.
    task automatic seq_byte(input t_char b);
        if ($urandom_range(0, 11) == 0) begin
            push_tick();
        end
        push_byte(b);
    endtask

    // Drops valid and waits until every predicted key has been taken.
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (keys_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
    endtask

    // Rewrites every register; upper data bits carry junk for the 8-bit codes.
    task automatic program_codes(input t_char bs, input t_char del, input t_char intr,
                                 input t_char eoi, input t_char enter,
                                 input logic [TICKS_W-1:0] limit);
        logic [7:0] pad;
        pad = 8'($urandom_range(0, 255));
        settle();
        write_reg(CFG_BACKSPACE, {pad, bs});
        write_reg(CFG_DELETE, {pad, del});
        write_reg(CFG_INTERRUPT, {pad, intr});
        write_reg(CFG_END_INPUT, {pad, eoi});
        write_reg(CFG_END_LINE, {pad, enter});
        write_reg(CFG_TIMEOUT, limit);
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    // Mostly well-formed key sequences with random content, plus plain
    // bytes, lone ESC timeouts and broken sequences.
    task automatic play_random(input int n);
        int    stop;
        int    pick;
        int    reps;
        t_char digit;
        t_char modc;
        stop = bytes_sent + n;
        while (bytes_sent < stop) begin
            if ($urandom_range(0, 29) == 0) begin
                calm = ~calm;
            end
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                seq_byte(CH_ESC);
                seq_byte(CH_BRACKET);
                case ($urandom_range(0, 2))
                    0: seq_byte(pick_letter());
                    1: begin
                        seq_byte(CH_ZERO + t_char'($urandom_range(0, 9)));
                        seq_byte(CH_TILDE);
                    end
                    default: begin
                        digit = CH_ONE;
                        if ($urandom_range(0, 3) == 0) begin
                            digit = CH_ZERO + t_char'($urandom_range(0, 9));
                        end
                        seq_byte(digit);
                        seq_byte(CH_SEMI);
                        if (digit == CH_ONE) begin
                            case ($urandom_range(0, 3))
                                0:       modc = CH_FIVE;
                                1:       modc = CH_TWO;
                                2:       modc = CH_SIX;
                                default: modc = t_char'($urandom_range(0, 255));
                            endcase
                            seq_byte(modc);
                            seq_byte(pick_letter());
                        end
                    end
                endcase
            end else if (pick < 60) begin
                // Lone ESC: often exactly the timeout, sometimes short or long.
                if (esc_limit > 120) begin
                    reps = $urandom_range(0, 120);
                end else if ($urandom_range(0, 2) == 0) begin
                    reps = $urandom_range(0, esc_limit + 1);
                end else begin
                    reps = esc_limit;
                end
                push_byte(CH_ESC);
                repeat (reps) push_tick();
            end else if (pick < 85) begin
                case ($urandom_range(0, 9))
                    0:       push_byte(bs_code);
                    1:       push_byte(del_code);
                    2:       push_byte(intr_code);
                    3:       push_byte(eoi_code);
                    4:       push_byte(enter_code);
                    default: push_byte(t_char'($urandom_range(0, 255)));
                endcase
            end else begin
                push_byte(CH_ESC);
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(CH_BRACKET);
                end
                reps = $urandom_range(1, 3);
                repeat (reps) push_byte(t_char'($urandom_range(0, 255)));
            end
        end
    endtask

    // Key receiver: random stall before each word it takes.
    initial begin : key_sink
        int stall;
        out_if.ready = 1'b0;
        forever begin
            stall = pause_len();
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    // Hang detection: any handshake restarts the count.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        t_row directed [0:22];
        int   i;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.operation  = OP_BYTE;
        in_if.data_byte  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_BACKSPACE;
        cfg_if.data      = '0;
        pin_on           = 1'b0;
        pin_has          = 1'b0;
        pin_word         = '0;
        calm             = 1'b0;
        errors           = 0;
        words_in         = 0;
        bytes_sent       = 0;
        keys_out         = 0;
        esc_keys         = 0;
        settings         = 1;

        // Columns: operation, byte, typed-in, key expected, key, char.
        // Extremes and the default control codes, then an idle tick.
        directed[0]  = {OP_BYTE, 8'h00,         1'b1, 1'b1, K_PLAIN, 8'h00};
        directed[1]  = {OP_BYTE, 8'hFF,         1'b1, 1'b1, K_PLAIN, 8'hFF};
        directed[2]  = {OP_BYTE, RST_BACKSPACE, 1'b1, 1'b1, K_BACK,  NO_CHAR};
        directed[3]  = {OP_BYTE, RST_DELETE,    1'b1, 1'b1, K_DEL,   NO_CHAR};
        directed[4]  = {OP_BYTE, RST_INTERRUPT, 1'b1, 1'b1, K_INTR,  NO_CHAR};
        directed[5]  = {OP_BYTE, RST_END_INPUT, 1'b1, 1'b1, K_EOI,   NO_CHAR};
        directed[6]  = {OP_BYTE, RST_END_LINE,  1'b1, 1'b1, K_ENTER, NO_CHAR};
        directed[7]  = {OP_TICK, 8'hFF,         1'b1, 1'b0, K_PLAIN, NO_CHAR};
        // Byte 0xFF after ESC is a byte, not a timeout.
        directed[8]  = {OP_BYTE, CH_ESC,        1'b1, 1'b0, K_PLAIN, NO_CHAR};
        directed[9]  = {OP_BYTE, 8'hFF,         1'b1, 1'b1, K_PLAIN, CH_ESC};
        // A digit other than one before the semicolon gives the escape key.
        directed[10] = {OP_BYTE, CH_ESC,        1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[11] = {OP_BYTE, CH_BRACKET,    1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[12] = {OP_BYTE, CH_FOUR,       1'b1, 1'b0, K_PLAIN, NO_CHAR};
        directed[13] = {OP_BYTE, CH_SEMI,       1'b1, 1'b1, K_ESC,   NO_CHAR};
        // Ctrl-shift home.
        directed[14] = {OP_BYTE, CH_ESC,        1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[15] = {OP_BYTE, CH_BRACKET,    1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[16] = {OP_BYTE, CH_ONE,        1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[17] = {OP_BYTE, CH_SEMI,       1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[18] = {OP_BYTE, CH_SIX,        1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[19] = {OP_BYTE, CH_H,          1'b0, 1'b0, K_PLAIN, NO_CHAR};
        // Shift-tab.
        directed[20] = {OP_BYTE, CH_ESC,        1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[21] = {OP_BYTE, CH_BRACKET,    1'b0, 1'b0, K_PLAIN, NO_CHAR};
        directed[22] = {OP_BYTE, CH_Z,          1'b1, 1'b1, K_SHIFTTAB, NO_CHAR};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 23; i++) begin
            send_word(directed[i]);
        end
        settle();

        // Reset codes with the default timeout.
        play_random(40);

        // Codes at the extremes; ESC as a code never matches; end-of-input and
        // enter share a code and end-of-input wins; shortest nonzero timeout.
        program_codes(8'h00, 8'hFF, CH_ESC, CH_A, CH_A, 16'd1);
        push_byte(CH_ESC);
        push_tick();
        play_random(70);

        // All five codes equal, so backspace wins; zero timeout fires on the first tick.
        program_codes(8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 16'd0);
        push_byte(CH_ESC);
        push_tick();
        play_random(70);

        // Longest timeout: a lone ESC stays pending through a burst of ticks
        // until a letter ends it as a raw ESC.
        program_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        calm = 1'b1;
        push_byte(CH_ESC);
        repeat (30) push_tick();
        push_byte(CH_A);
        calm = 1'b0;
        play_random(10);

        // Random codes and a short timeout.
        program_codes(t_char'($urandom_range(0, 255)), t_char'($urandom_range(0, 255)),
                      t_char'($urandom_range(0, 255)), t_char'($urandom_range(0, 255)),
                      t_char'($urandom_range(0, 255)), TICKS_W'($urandom_range(2, 6)));
        play_random(110);

        settle();
        if (out_if.valid) begin
            note_mismatch("key left on the output after the last expected one");
        end
        $display("Run covered %0d input words (%0d bytes) and %0d decoded keys, %0d of them ESC.",
                 words_in, bytes_sent, keys_out, esc_keys);
        $display("Register settings used: %0d; mismatches: %0d.", settings, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
